// File: rtl/three_axis_stepper_sequencer_defines.svh
// assertion macros for the three-axis stepper sequencer
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef THREE_AXIS_STEPPER_SEQUENCER_DEFINES_SVH
`define THREE_AXIS_STEPPER_SEQUENCER_DEFINES_SVH

// same-cycle implication, masked during reset
`define TASS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define TASS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tass_pkg.sv
// shared types and constants for the three-axis stepper sequencer
// no dependencies
package tass_pkg;

  localparam int PosW  = 8;
  localparam int CntW  = 8;
  localparam int OpW   = 2;
  localparam int RegIdxW = 3;
  localparam int CfgW  = 8;
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  // item opcodes
  localparam logic [OpW-1:0] OP_TICK    = 2'd0;
  localparam logic [OpW-1:0] OP_TARGETS = 2'd1;
  localparam logic [OpW-1:0] OP_FIRE    = 2'd2;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] REG_DIAL_UPPER  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_DIAL_LOWER  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_TILT_UPPER  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TILT_LOWER  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_FIRE_STROKE = 3'd4;

  // register reset values
  localparam logic signed [PosW-1:0] DIAL_UPPER_RST  = 8'sd100;
  localparam logic signed [PosW-1:0] DIAL_LOWER_RST  = -8'sd100;
  localparam logic signed [PosW-1:0] TILT_UPPER_RST  = 8'sd50;
  localparam logic signed [PosW-1:0] TILT_LOWER_RST  = 8'sd0;
  localparam logic [CntW-1:0]        FIRE_STROKE_RST = 8'd70;

  // one result item, highest bit first when packed into tdata
  typedef struct packed {
    logic                   fire_busy;
    logic                   clock_running;
    logic signed [PosW-1:0] tilt_now;
    logic signed [PosW-1:0] dial_now;
    logic                   fire_forward;
    logic                   tilt_forward;
    logic                   dial_forward;
    logic                   fire_pulse;
    logic                   tilt_pulse;
    logic                   dial_pulse;
  } result_t;

endpackage

// File: rtl/three_axis_stepper_sequencer.sv
// three-axis stepper sequencer: step/direction generation for dial, tilt and fire axes
// depends on tass_pkg and three_axis_stepper_sequencer_defines.svh
//
//  channel    | dir | handshake               | payload
//  -----------+-----+-------------------------+----------------------------------------
//  s_axis     | in  | s_axis_tvalid/tready    | tuser op, tdata dial_goal, tilt_goal
//  m_axis     | out | m_axis_tvalid/tready    | pulses, directions, positions, flags
//  cfg        | in  | cfg_write (no wait)     | cfg_index, cfg_data
//
// one item per cycle while m_axis is not stalled: the axis state is updated and the result
// register loaded on the same edge that takes the transfer, so a result appears in the cycle after its item.
// s_axis_tready stays high while the result register is empty or being drained, so
// input and output only couple through that single result register.
// rst is synchronous: axis state, result valid and the limit registers return to defaults.
// a stall on m_axis holds the result and backs up s_axis after one item.
`include "three_axis_stepper_sequencer_defines.svh"

module three_axis_stepper_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] op
  input  logic [tass_pkg::OpW-1:0]         s_axis_tuser,
  // [7:0] dial_goal, [15:8] tilt_goal
  input  logic [tass_pkg::InDataW-1:0]     s_axis_tdata,
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] dial_pulse, [1] tilt_pulse, [2] fire_pulse, [3] dial_forward, [4] tilt_forward,
  // [5] fire_forward, [13:6] dial_now, [21:14] tilt_now, [22] clock_running,
  // [23] fire_busy
  output logic [tass_pkg::OutDataW-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                             cfg_write,
  input  logic [tass_pkg::RegIdxW-1:0]     cfg_index,
  input  logic [tass_pkg::CfgW-1:0]        cfg_data
);

  // limit and stroke registers
  logic signed [tass_pkg::PosW-1:0] dial_upper, dial_lower, tilt_upper, tilt_lower;
  logic [tass_pkg::CntW-1:0]        fire_stroke;

  // axis state
  logic signed [tass_pkg::PosW-1:0] dial_pos, tilt_pos;
  logic [tass_pkg::CntW-1:0]        dial_left, tilt_left, fire_left;
  logic dial_fwd, tilt_fwd, fire_fwd, fire_return, fire_active, clock_on;

  logic signed [tass_pkg::PosW-1:0] dial_pos_next, tilt_pos_next;
  logic [tass_pkg::CntW-1:0]        dial_left_next, tilt_left_next, fire_left_next;
  logic dial_fwd_next, tilt_fwd_next, fire_fwd_next, fire_return_next;
  logic fire_active_next, clock_on_next;

  logic                         in_xfer;
  logic [tass_pkg::OpW-1:0]     op;
  logic signed [tass_pkg::PosW-1:0] dial_goal, tilt_goal;
  logic signed [tass_pkg::PosW-1:0] dial_tgt, tilt_tgt;
  logic signed [tass_pkg::PosW:0]   dial_delta, tilt_delta;
  logic dial_step, tilt_step, fire_step;
  logic work_left;
  tass_pkg::result_t result_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign op        = s_axis_tuser;
  assign dial_goal = s_axis_tdata[7:0];
  assign tilt_goal = s_axis_tdata[15:8];

  // clamp: upper first, then lower, so crossed limits resolve to the lower one
  always_comb begin
    dial_tgt = (dial_goal > dial_upper) ? dial_upper : dial_goal;
    if (dial_tgt < dial_lower) begin
      dial_tgt = dial_lower;
    end
    tilt_tgt = (tilt_goal > tilt_upper) ? tilt_upper : tilt_goal;
    if (tilt_tgt < tilt_lower) begin
      tilt_tgt = tilt_lower;
    end
  end

  // 9-bit deltas cover the full -255..255 span
  assign dial_delta = {dial_tgt[tass_pkg::PosW-1], dial_tgt}
                    - {dial_pos[tass_pkg::PosW-1], dial_pos};
  assign tilt_delta = {tilt_tgt[tass_pkg::PosW-1], tilt_tgt}
                    - {tilt_pos[tass_pkg::PosW-1], tilt_pos};

  always_comb begin
    dial_pos_next    = dial_pos;
    tilt_pos_next    = tilt_pos;
    dial_left_next   = dial_left;
    tilt_left_next   = tilt_left;
    fire_left_next   = fire_left;
    dial_fwd_next    = dial_fwd;
    tilt_fwd_next    = tilt_fwd;
    fire_fwd_next    = fire_fwd;
    fire_return_next = fire_return;
    fire_active_next = fire_active;
    clock_on_next    = clock_on;
    dial_step        = 1'b0;
    tilt_step        = 1'b0;
    fire_step        = 1'b0;

    case (op)
      tass_pkg::OP_TARGETS: begin
        // zero delta points the axis backward
        dial_fwd_next  = !dial_delta[tass_pkg::PosW] && (dial_delta != '0);
        tilt_fwd_next  = !tilt_delta[tass_pkg::PosW] && (tilt_delta != '0);
        dial_left_next = dial_delta[tass_pkg::PosW] ? 8'(-dial_delta) : dial_delta[7:0];
        tilt_left_next = tilt_delta[tass_pkg::PosW] ? 8'(-tilt_delta) : tilt_delta[7:0];
        if (dial_left_next != '0 || tilt_left_next != '0) begin
          clock_on_next = 1'b1;
        end
      end
      tass_pkg::OP_FIRE: begin
        // restarts from the forward run even if a sequence is under way
        fire_return_next = 1'b0;
        fire_fwd_next    = 1'b1;
        fire_active_next = 1'b1;
        fire_left_next   = fire_stroke;
        clock_on_next    = 1'b1;
      end
      tass_pkg::OP_TICK: begin
        if (clock_on) begin
          if (dial_left != '0) begin
            dial_step      = 1'b1;
            dial_left_next = dial_left - 8'd1;
            dial_pos_next  = dial_fwd ? dial_pos + 8'sd1 : dial_pos - 8'sd1;
          end
          if (tilt_left != '0) begin
            tilt_step      = 1'b1;
            tilt_left_next = tilt_left - 8'd1;
            tilt_pos_next  = tilt_fwd ? tilt_pos + 8'sd1 : tilt_pos - 8'sd1;
          end
          // end of a run costs one tick without a pulse
          if (fire_left != '0) begin
            fire_step      = 1'b1;
            fire_left_next = fire_left - 8'd1;
          end else if (fire_active && !fire_return) begin
            fire_return_next = 1'b1;
            fire_fwd_next    = 1'b0;
            fire_left_next   = fire_stroke;
          end else if (fire_active) begin
            fire_active_next = 1'b0;
          end
          if (dial_left_next == '0 && tilt_left_next == '0 && fire_left_next == '0
              && !fire_active_next) begin
            clock_on_next = 1'b0;
          end
        end
      end
      default: begin
        // unused opcode leaves the state alone
      end
    endcase
  end

  always_comb begin
    result_next.dial_pulse    = dial_step;
    result_next.tilt_pulse    = tilt_step;
    result_next.fire_pulse    = fire_step;
    result_next.dial_forward  = dial_fwd_next;
    result_next.tilt_forward  = tilt_fwd_next;
    result_next.fire_forward  = fire_fwd_next;
    result_next.dial_now      = dial_pos_next;
    result_next.tilt_now      = tilt_pos_next;
    result_next.clock_running = clock_on_next;
    result_next.fire_busy     = fire_active_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dial_upper  <= tass_pkg::DIAL_UPPER_RST;
      dial_lower  <= tass_pkg::DIAL_LOWER_RST;
      tilt_upper  <= tass_pkg::TILT_UPPER_RST;
      tilt_lower  <= tass_pkg::TILT_LOWER_RST;
      fire_stroke <= tass_pkg::FIRE_STROKE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tass_pkg::REG_DIAL_UPPER:  dial_upper  <= cfg_data;
        tass_pkg::REG_DIAL_LOWER:  dial_lower  <= cfg_data;
        tass_pkg::REG_TILT_UPPER:  tilt_upper  <= cfg_data;
        tass_pkg::REG_TILT_LOWER:  tilt_lower  <= cfg_data;
        tass_pkg::REG_FIRE_STROKE: fire_stroke <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // axis state, updated on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      dial_pos    <= '0;
      tilt_pos    <= '0;
      dial_left   <= '0;
      tilt_left   <= '0;
      fire_left   <= '0;
      dial_fwd    <= 1'b0;
      tilt_fwd    <= 1'b0;
      fire_fwd    <= 1'b0;
      fire_return <= 1'b0;
      fire_active <= 1'b0;
      clock_on    <= 1'b0;
    end else if (in_xfer) begin
      dial_pos    <= dial_pos_next;
      tilt_pos    <= tilt_pos_next;
      dial_left   <= dial_left_next;
      tilt_left   <= tilt_left_next;
      fire_left   <= fire_left_next;
      dial_fwd    <= dial_fwd_next;
      tilt_fwd    <= tilt_fwd_next;
      fire_fwd    <= fire_fwd_next;
      fire_return <= fire_return_next;
      fire_active <= fire_active_next;
      clock_on    <= clock_on_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_axis_tdata <= result_next;
    end
  end

  // any axis still owes steps or the fire sequence is busy
  assign work_left = (dial_left != '0) || (tilt_left != '0) || (fire_left != '0)
                   || fire_active;

  `TASS_ASSERT_IMPL(a_idle_fire_empty, !fire_active, fire_left == '0, "fire count while idle")
  `TASS_ASSERT_IMPL(a_stopped_no_work, !clock_on, !work_left, "clock stopped with work left")
  `TASS_ASSERT_NEXT(a_result_follows, in_xfer, m_axis_tvalid, "no result after transfer")
  `TASS_ASSERT_IMPL(a_return_backward, fire_return, !fire_fwd, "return run not backward")

endmodule
